// ===== src/distance_vector_route_update_core_macros.svh =====
// ----------------------------------------------------------------------------
// distance vector route update core assertion macros
// shared assertion forms for the routing table core
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_CORE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_CORE_MACROS_SVH

// same-cycle implication
`define DVR_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication
`define DVR_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== src/dvr_pkg.sv =====
// ----------------------------------------------------------------------------
// dvr_pkg
// types and constants shared by the routing table update core
// ----------------------------------------------------------------------------
package dvr_pkg;

  localparam logic [15:0] DIST_INF = 16'hFFFF;

  localparam logic [1:0] ACT_LOAD     = 2'd0;
  localparam logic [1:0] ACT_ADVERT   = 2'd1;
  localparam logic [1:0] ACT_ANNOUNCE = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_ADVERT,
    CMD_ANNOUNCE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  nb;
    logic [2:0]  dest;
    logic [15:0] cost;
    logic        last;
    logic        relax;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  hop;
    logic [15:0] cost;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RELAX,
    BK_EMIT_RD,
    BK_EMIT_WR
  } back_state_t;

endpackage

// ===== src/distance_vector_route_update_core.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_update_core
// distance vector routing table with relaxation of neighbor adverts
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ------------------------------------------
//  input     in_valid / in_ready    action, neighbor, dest, distance, last
//  output    out_valid / out_ready  out_dest, out_distance, out_next_hop,
//                                   out_last
//
//  a two-word command queue parts the input side from the table sequencer
//  load: one table write in the sequencer; advert element: table read, then
//  add, compare and write back through the single write port
//  table emission: one entry per cycle while out_ready holds
//  reset clears the entry valid bits directly, no clearing pass
//  a stalled output holds the sequencer; the queue keeps taking words until full
//
`include "distance_vector_route_update_core_macros.svh"

module distance_vector_route_update_core #(
  parameter int NODES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [2:0]  neighbor,
  input  logic [2:0]  dest,
  input  logic [15:0] distance,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_dest,
  output logic [15:0] out_distance,
  output logic [2:0]  out_next_hop,
  output logic        out_last
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  logic            cmd_valid;
  logic            cmd_ready;
  dvr_pkg::cmd_t   cmd;
  logic            we;
  logic [AW-1:0]   waddr;
  dvr_pkg::entry_t wdata;
  logic            re_a;
  logic [AW-1:0]   raddr_a;
  dvr_pkg::entry_t rdata_a;
  logic            re_b;
  logic [AW-1:0]   raddr_b;
  dvr_pkg::entry_t rdata_b;
  logic            emitting;
  logic            out_fire;

  dvr_front #(
    .NODES (NODES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .neighbor  (neighbor),
    .dest      (dest),
    .distance  (distance),
    .last      (last),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dvr_back #(
    .NODES (NODES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .we           (we),
    .waddr        (waddr),
    .wdata        (wdata),
    .re_a         (re_a),
    .raddr_a      (raddr_a),
    .rdata_a      (rdata_a),
    .re_b         (re_b),
    .raddr_b      (raddr_b),
    .rdata_b      (rdata_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_dest     (out_dest),
    .out_distance (out_distance),
    .out_next_hop (out_next_hop),
    .out_last     (out_last),
    .emitting     (emitting)
  );

  dvr_ram #(
    .WIDTH (dvr_pkg::ENTRY_W),
    .DEPTH (NODES)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign out_fire = out_valid && out_ready;

  `DVR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_dest) && $stable(out_distance), "word dropped while stalled")
  `DVR_ASSERT_NEXT(a_table_streams, clk, rst, out_fire && !out_last, out_valid, "table gap")
  `DVR_ASSERT_NOW(a_partial_table, clk, rst, out_valid && !out_last, emitting, "stray entry")

endmodule

// ===== src/dvr_ram.sv =====
// ----------------------------------------------------------------------------
// dvr_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module dvr_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== src/dvr_front.sv =====
// ----------------------------------------------------------------------------
// dvr_front
// accepts input words, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
module dvr_front #(
  parameter int NODES = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    action,
  input  logic [2:0]    neighbor,
  input  logic [2:0]    dest,
  input  logic [15:0]   distance,
  input  logic          last,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output dvr_pkg::cmd_t cmd
);

  dvr_pkg::cmd_t cmd_in;
  logic          keep;
  logic          nb_ok;
  logic          dest_ok;
  logic          push;
  logic          pop;
  dvr_pkg::cmd_t q [2];
  logic          wp;
  logic          rp;
  logic [1:0]    count;

  assign nb_ok   = 32'(neighbor) < NODES;
  assign dest_ok = 32'(dest) < NODES;

  always_comb begin
    cmd_in.kind  = dvr_pkg::CMD_LOAD;
    cmd_in.nb    = neighbor;
    cmd_in.dest  = dest;
    cmd_in.cost  = distance;
    cmd_in.last  = last;
    cmd_in.relax = 1'b0;
    keep         = 1'b0;
    unique case (action)
      dvr_pkg::ACT_LOAD: begin
        keep = dest_ok;
      end
      dvr_pkg::ACT_ADVERT: begin
        cmd_in.kind  = dvr_pkg::CMD_ADVERT;
        cmd_in.relax = nb_ok && dest_ok && (distance != dvr_pkg::DIST_INF);
        keep         = cmd_in.relax || last;
      end
      dvr_pkg::ACT_ANNOUNCE: begin
        cmd_in.kind = dvr_pkg::CMD_ANNOUNCE;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rp];
  assign push      = in_valid && in_ready && keep;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cmd_in;
    end
  end

endmodule

// ===== src/dvr_back.sv =====
// ----------------------------------------------------------------------------
// dvr_back
// carries out table loads, relaxation steps and table emission
// ----------------------------------------------------------------------------
module dvr_back #(
  parameter int NODES = 8,
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  dvr_pkg::cmd_t   cmd,
  output logic            we,
  output logic [AW-1:0]   waddr,
  output dvr_pkg::entry_t wdata,
  output logic            re_a,
  output logic [AW-1:0]   raddr_a,
  input  dvr_pkg::entry_t rdata_a,
  output logic            re_b,
  output logic [AW-1:0]   raddr_b,
  input  dvr_pkg::entry_t rdata_b,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_dest,
  output logic [15:0]     out_distance,
  output logic [2:0]      out_next_hop,
  output logic            out_last,
  output logic            emitting
);

  dvr_pkg::back_state_t state;
  dvr_pkg::back_state_t state_next;
  logic                 changed;
  logic                 changed_next;
  logic [AW-1:0]        k;
  logic [AW-1:0]        k_next;
  logic [NODES-1:0]     valid;
  logic                 va;
  logic                 vb;
  dvr_pkg::cmd_t        cmd_q;
  logic                 latch_cmd;
  logic                 out_load;
  dvr_pkg::entry_t      own;
  dvr_pkg::entry_t      cur;
  logic [16:0]          sum;
  logic                 upd;
  logic                 k_end;

  // entries never written read as the reset value
  assign own.hop  = va ? rdata_a.hop : 3'd0;
  assign own.cost = va ? rdata_a.cost : dvr_pkg::DIST_INF;
  assign cur.hop  = vb ? rdata_b.hop : 3'd0;
  assign cur.cost = vb ? rdata_b.cost : dvr_pkg::DIST_INF;

  assign sum   = {1'b0, own.cost} + {1'b0, cmd_q.cost};
  assign upd   = cmd_q.relax && (own.cost != dvr_pkg::DIST_INF)
                 && (sum < {1'b0, dvr_pkg::DIST_INF}) && ({1'b0, cur.cost} > sum);
  assign k_end = (k == AW'(NODES - 1));

  assign emitting = (state == dvr_pkg::BK_EMIT_RD) || (state == dvr_pkg::BK_EMIT_WR);

  always_comb begin
    state_next   = state;
    changed_next = changed;
    k_next       = k;
    cmd_ready    = 1'b0;
    latch_cmd    = 1'b0;
    out_load     = 1'b0;
    we           = 1'b0;
    waddr        = AW'(cmd.dest);
    wdata.hop    = cmd.nb;
    wdata.cost   = cmd.cost;
    re_a         = 1'b0;
    raddr_a      = AW'(cmd.nb);
    re_b         = 1'b0;
    raddr_b      = AW'(cmd.dest);
    unique case (state)
      dvr_pkg::BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          unique case (cmd.kind)
            dvr_pkg::CMD_LOAD: begin
              we = 1'b1;
            end
            dvr_pkg::CMD_ADVERT: begin
              re_a       = 1'b1;
              re_b       = 1'b1;
              latch_cmd  = 1'b1;
              state_next = dvr_pkg::BK_RELAX;
            end
            dvr_pkg::CMD_ANNOUNCE: begin
              k_next     = '0;
              state_next = dvr_pkg::BK_EMIT_RD;
            end
            default: begin
              state_next = dvr_pkg::BK_IDLE;
            end
          endcase
        end
      end
      dvr_pkg::BK_RELAX: begin
        waddr      = AW'(cmd_q.dest);
        wdata.hop  = cmd_q.nb;
        wdata.cost = sum[15:0];
        we         = upd;
        if (cmd_q.last && (changed || upd)) begin
          changed_next = 1'b0;
          k_next       = '0;
          state_next   = dvr_pkg::BK_EMIT_RD;
        end else begin
          changed_next = changed || upd;
          state_next   = dvr_pkg::BK_IDLE;
        end
      end
      dvr_pkg::BK_EMIT_RD: begin
        re_a       = 1'b1;
        raddr_a    = k;
        state_next = dvr_pkg::BK_EMIT_WR;
      end
      dvr_pkg::BK_EMIT_WR: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          if (k_end) begin
            state_next = dvr_pkg::BK_IDLE;
          end else begin
            k_next  = AW'(k + 1'b1);
            re_a    = 1'b1;
            raddr_a = AW'(k + 1'b1);
          end
        end
      end
      default: begin
        state_next = dvr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dvr_pkg::BK_IDLE;
      changed   <= 1'b0;
      k         <= '0;
      valid     <= '0;
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      changed <= changed_next;
      k       <= k_next;
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re_a) begin
        va <= valid[raddr_a];
      end
      if (re_b) begin
        vb <= valid[raddr_b];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (latch_cmd) begin
      cmd_q <= cmd;
    end
    if (out_load) begin
      out_dest     <= 3'(k);
      out_distance <= own.cost;
      out_next_hop <= own.hop;
      out_last     <= k_end;
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the distance vector route update core: a scoreboard
// model of the routing table predicts every emitted table word; directed corner
// cases run with no idle or stall, while random traffic, mostly neighbor adverts,
// runs under several idle and stall mixes on both valid/ready channels
// ----------------------------------------------------------------------------
module tb;

  localparam int NODES = 8;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [2:0]  dest;
    logic [15:0] cost;
    logic [2:0]  hop;
    logic        last;
  } route_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [2:0]  neighbor = '0;
  logic [2:0]  dest = '0;
  logic [15:0] distance = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_dest;
  logic [15:0] out_distance;
  logic [2:0]  out_next_hop;
  logic        out_last;

  dvr_pkg::entry_t route_tbl [NODES];
  logic            route_changed;
  route_word_t     table_words_q [$];

  int sender_idle_pct = 0;
  int rcv_stall_pct = 0;
  int words_sent = 0;
  int table_words_seen = 0;
  int tables_predicted = 0;
  int failures = 0;
  int quiet_cycles = 0;

  distance_vector_route_update_core #(.NODES(NODES)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .neighbor(neighbor),
    .dest(dest),
    .distance(distance),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_dest(out_dest),
    .out_distance(out_distance),
    .out_next_hop(out_next_hop),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_failure(input string what);
    failures++;
    if (failures <= 10) begin
      $display("[%0t] %s", $time, what);
    end
  endtask

  function automatic void route_reset();
    for (int i = 0; i < NODES; i++) begin
      route_tbl[i].cost = dvr_pkg::DIST_INF;
      route_tbl[i].hop = '0;
    end
    route_changed = 1'b0;
  endfunction

  function automatic void push_table_words();
    route_word_t w;
    for (int i = 0; i < NODES; i++) begin
      w.dest = i[2:0];
      w.cost = route_tbl[i].cost;
      w.hop = route_tbl[i].hop;
      w.last = (i == NODES - 1);
      table_words_q.push_back(w);
    end
    tables_predicted++;
  endfunction

  function automatic void route_predict(input logic [1:0] act, input logic [2:0] nb,
                                        input logic [2:0] dst, input logic [15:0] dval,
                                        input logic lst);
    logic [15:0] own;
    logic [16:0] sum;
    case (act)
      dvr_pkg::ACT_LOAD: begin
        route_tbl[dst].cost = dval;
        route_tbl[dst].hop = nb;
      end
      dvr_pkg::ACT_ADVERT: begin
        own = route_tbl[nb].cost;
        if (own != dvr_pkg::DIST_INF && dval != dvr_pkg::DIST_INF) begin
          sum = {1'b0, own} + {1'b0, dval};
          if (sum > {1'b0, dvr_pkg::DIST_INF}) sum = {1'b0, dvr_pkg::DIST_INF};
          if ({1'b0, route_tbl[dst].cost} > sum) begin
            route_tbl[dst].cost = sum[15:0];
            route_tbl[dst].hop = nb;
            route_changed = 1'b1;
          end
        end
        if (lst && route_changed) begin
          route_changed = 1'b0;
          push_table_words();
        end
      end
      dvr_pkg::ACT_ANNOUNCE: push_table_words();
      default: ;
    endcase
  endfunction

  // valid stays high between back-to-back words; it drops only for a gap
  task automatic send_word(input logic [1:0] act, input logic [2:0] nb, input logic [2:0] dst,
                           input logic [15:0] dval, input logic lst);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    action <= act;
    neighbor <= nb;
    dest <= dst;
    distance <= dval;
    last <= lst;
    do @(posedge clk); while (!in_ready);
    route_predict(act, nb, dst, dval, lst);
    if (act != ACT_UNUSED) words_sent++;
  endtask

  task automatic wait_table_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (table_words_q.size() != 0);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    route_word_t got;
    route_word_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{out_dest, out_distance, out_next_hop, out_last};
      table_words_seen++;
      if (table_words_q.size() == 0) begin
        note_failure($sformatf("unexpected word dest=%0d dist=%0d hop=%0d last=%0d",
                               got.dest, got.cost, got.hop, got.last));
      end else begin
        want = table_words_q.pop_front();
        if (got !== want) begin
          note_failure($sformatf(
            "word mismatch exp dest=%0d dist=%0d hop=%0d last=%0d, got %0d %0d %0d %0d",
            want.dest, want.cost, want.hop, want.last,
            got.dest, got.cost, got.hop, got.last));
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [15:0] pick_distance();
    int r;
    r = $urandom_range(99);
    if (r < 15) return dvr_pkg::DIST_INF;
    if (r < 22) return 16'hFFFE;
    if (r < 30) return 16'd0;
    if (r < 45) return 16'($urandom);
    return 16'($urandom_range(1, 300));
  endfunction

  task automatic test_reset_announce();
    send_word(dvr_pkg::ACT_ANNOUNCE, 3'd5, 3'd2, 16'h1234, 1'b1);
    send_word(dvr_pkg::ACT_ADVERT, 3'd3, 3'd0, 16'd5, 1'b1);
  endtask

  task automatic test_load_and_ignored();
    send_word(dvr_pkg::ACT_LOAD, 3'd0, 3'd0, 16'd0, 1'b1);
    send_word(dvr_pkg::ACT_LOAD, 3'd7, 3'd7, 16'hFFFE, 1'b0);
    send_word(dvr_pkg::ACT_LOAD, 3'd5, 3'd4, dvr_pkg::DIST_INF, 1'b0);
    send_word(ACT_UNUSED, 3'd7, 3'd7, 16'hFFFF, 1'b1);
    send_word(dvr_pkg::ACT_ANNOUNCE, 3'd0, 3'd0, 16'd0, 1'b0);
  endtask

  task automatic test_relax_edges();
    send_word(dvr_pkg::ACT_ADVERT, 3'd0, 3'd5, dvr_pkg::DIST_INF, 1'b0);
    send_word(dvr_pkg::ACT_ADVERT, 3'd7, 3'd3, 16'd1, 1'b0);
    send_word(dvr_pkg::ACT_ADVERT, 3'd7, 3'd3, 16'd0, 1'b0);
    send_word(dvr_pkg::ACT_ADVERT, 3'd0, 3'd6, 16'hFFFE, 1'b1);
    send_word(dvr_pkg::ACT_ADVERT, 3'd0, 3'd5, 16'd10, 1'b0);
    // neighbor's own entry rewritten in the middle of its advert
    send_word(dvr_pkg::ACT_LOAD, 3'd1, 3'd0, 16'd3, 1'b0);
    send_word(dvr_pkg::ACT_ADVERT, 3'd0, 3'd2, 16'd4, 1'b0);
    send_word(dvr_pkg::ACT_ADVERT, 3'd0, 3'd0, 16'd0, 1'b1);
  endtask

  task automatic test_flag_behavior();
    send_word(dvr_pkg::ACT_ADVERT, 3'd0, 3'd1, 16'd1, 1'b0);
    send_word(dvr_pkg::ACT_ANNOUNCE, 3'd2, 3'd6, 16'd9, 1'b1);
    send_word(dvr_pkg::ACT_ADVERT, 3'd0, 3'd1, 16'd50, 1'b1);
    send_word(dvr_pkg::ACT_ADVERT, 3'd0, 3'd1, 16'd50, 1'b1);
    wait_table_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int target;
    int kind;
    int len;
    logic [2:0] nb;
    target = words_sent + count;
    sender_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    while (words_sent < target) begin
      kind = $urandom_range(99);
      nb = 3'($urandom_range(NODES - 1));
      if (kind < 15) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          send_word(dvr_pkg::ACT_LOAD, 3'($urandom), 3'($urandom),
                    ($urandom_range(3) == 0) ? dvr_pkg::DIST_INF : 16'($urandom),
                    1'($urandom));
        end
      end else if (kind < 75) begin
        if ($urandom_range(1) == 1) begin
          send_word(dvr_pkg::ACT_LOAD, nb, nb, 16'($urandom_range(0, 400)), 1'b0);
        end
        for (int d = 0; d < NODES; d++) begin
          send_word(dvr_pkg::ACT_ADVERT, nb, 3'(d), pick_distance(), d == NODES - 1);
        end
      end else if (kind < 85) begin
        send_word(dvr_pkg::ACT_ANNOUNCE, 3'($urandom), 3'($urandom), 16'($urandom),
                  1'($urandom));
      end else if (kind < 95) begin
        send_word(2'($urandom), 3'($urandom), 3'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        len = $urandom_range(1, NODES - 1);
        for (int i = 0; i < len; i++) begin
          send_word(dvr_pkg::ACT_ADVERT, nb, 3'($urandom), pick_distance(),
                    ($urandom_range(3) == 0));
        end
      end
    end
  endtask

  initial begin
    route_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_announce();
    test_load_and_ignored();
    test_relax_edges();
    test_flag_behavior();
    test_random_traffic(0, 0, 75);
    wait_table_drained();
    test_random_traffic(57, 0, 75);
    wait_table_drained();
    test_random_traffic(0, 57, 75);
    wait_table_drained();
    test_random_traffic(10, 10, 75);
    wait_table_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_words_q.size() != 0) begin
      note_failure($sformatf("%0d table words never arrived", table_words_q.size()));
    end
    $display("covered %0d input words and %0d table emissions (%0d table words checked)",
             words_sent, tables_predicted, table_words_seen);
    $display("idle mixes: none, sender 57%%, receiver 57%%, both 10%%; %0d failures", failures);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
